>>> sv/joystick_axis_deadzone_mapper_assert.svh
// Assertion macros shared by the joystick dead-zone mapper RTL
`ifndef JOYSTICK_AXIS_DEADZONE_MAPPER_ASSERT_SVH
`define JOYSTICK_AXIS_DEADZONE_MAPPER_ASSERT_SVH

// Same-cycle implication, masked during reset
`define JADM_CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jadm: same-cycle check failed");

// Next-cycle implication, masked during reset
`define JADM_CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jadm: next-cycle check failed");

`endif

>>> sv/jadm_pkg.sv
// Shared types and constants of the joystick dead-zone mapper
`default_nettype none

package jadm_pkg;

    // Field widths
    localparam int JADM_CNT_W  = 17;
    localparam int JADM_AXIS_W = 18;
    localparam int JADM_ST_W   = 8;
    localparam int JADM_WIDE_W = 19;
    localparam int JADM_Q_W    = 7;

    // One quotient bit per divider stage
    localparam int JADM_DIV_STEPS = JADM_Q_W;
    // Prep stage, region stage, divider stages, output register
    localparam int JADM_N_STG = JADM_DIV_STEPS + 3;

    // Stream payload widths, padded to whole bytes
    localparam int JADM_IN_W  = 48;
    localparam int JADM_OUT_W = 48;

    // Status byte button bits (active low)
    localparam int JADM_BTN1_BIT = 4;
    localparam int JADM_BTN2_BIT = 5;

    // Calibrated output limits
    localparam logic signed [JADM_AXIS_W-1:0] JADM_AXIS_LO = -18'sd128;
    localparam logic signed [JADM_AXIS_W-1:0] JADM_AXIS_HI = 18'sd128;
    localparam logic signed [JADM_AXIS_W-1:0] JADM_AXIS_ZERO = 18'sd0;

    // Register indexes on the config port
    typedef enum logic [2:0] {
        CFG_CENTRE_X   = 3'd0,
        CFG_CENTRE_Y   = 3'd1,
        CFG_MIN_X      = 3'd2,
        CFG_MIN_Y      = 3'd3,
        CFG_MAX_X      = 3'd4,
        CFG_MAX_Y      = 3'd5,
        CFG_CALIBRATED = 3'd6
    } t_cfg_idx;

    // Calibration register set
    typedef struct packed {
        logic [JADM_CNT_W-1:0] centre_x;
        logic [JADM_CNT_W-1:0] centre_y;
        logic [JADM_CNT_W-1:0] min_x;
        logic [JADM_CNT_W-1:0] min_y;
        logic [JADM_CNT_W-1:0] max_x;
        logic [JADM_CNT_W-1:0] max_y;
        logic                  calibrated;
    } t_cfg;

    // Per-axis payload through the divider stages
    typedef struct packed {
        logic [JADM_CNT_W-1:0]         rem;     // partial remainder, below dvs whenever use_q is set
        logic [JADM_CNT_W-1:0]         dvs;     // segment length
        logic [JADM_Q_W-1:0]           quo;     // quotient bits so far
        logic signed [JADM_AXIS_W-1:0] base;    // value before the scaled term
        logic                          neg;     // subtract the quotient
        logic                          use_q;   // quotient takes part
        logic                          flag_lo; // below half the centre
        logic                          flag_hi; // above one and a half times the centre
    } t_div;

endpackage

`default_nettype wire

>>> sv/joystick_axis_deadzone_mapper.sv
// Top level of the joystick dead-zone mapper: stream ports and pipeline control
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   raw_x, raw_y, port_status
//  m_axis    out        m_axis_tvalid/m_axis_tready   axis_x, axis_y, dir flags, buttons
//  cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
//  One sample per cycle while the output is not stalled by m_axis_tready.
//  Stages: margins and flags, segment select, 7 restoring divider steps, output register.
//  Each stage has its own valid bit and loads when empty or when the next stage moves,
//  so bubbles are squeezed out and input continues while a result waits, until all stages are full.
//  Synchronous active-low reset clears the valid bits and the calibration registers.
`default_nettype none
`include "joystick_axis_deadzone_mapper_assert.svh"

module joystick_axis_deadzone_mapper (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // raw_x [16:0], raw_y [33:17], port_status [41:34], zero [47:42]
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [jadm_pkg::JADM_IN_W-1:0]    s_axis_tdata,
    // axis_x [17:0], axis_y [35:18], dir_left 36, dir_right 37, dir_up 38,
    // dir_down 39, button_one 40, button_two 41, zero [47:42]
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [jadm_pkg::JADM_OUT_W-1:0]        m_axis_tdata,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [2:0]                        i_cfg_index,
    input  wire logic [jadm_pkg::JADM_CNT_W-1:0]   i_cfg_data
);

    localparam int CW   = jadm_pkg::JADM_CNT_W;
    localparam int AW   = jadm_pkg::JADM_AXIS_W;
    localparam int QW   = jadm_pkg::JADM_Q_W;
    localparam int NDIV = jadm_pkg::JADM_DIV_STEPS;
    localparam int NSTG = jadm_pkg::JADM_N_STG;
    localparam int LAST = NSTG - 1;
    localparam int ST_LSB = 2 * CW;

    jadm_pkg::t_cfg w_cfg;
    jadm_pkg::t_div w_div_x [0:NDIV];
    jadm_pkg::t_div w_div_y [0:NDIV];

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;
    logic [1:0]      r_btn [0:LAST];

    logic signed [AW-1:0] w_qx, w_qy, w_axis_x, w_axis_y;
    logic signed [AW-1:0] r_axis_x, r_axis_y;
    logic [3:0]           r_dir;

    // Calibration registers
    jadm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Stage enables: a stage loads when empty or when the one after it moves
    assign w_en[LAST] = !r_vld[LAST] || m_axis_tready;
    genvar g;
    generate
        for (g = 0; g < LAST; g++) begin : g_en
            assign w_en[g] = !r_vld[g] || w_en[g+1];
        end
    endgenerate

    assign s_axis_tready = w_en[0];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= (k == 0) ? s_axis_tvalid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // Front stages per axis
    jadm_axis_prep u_prep_x (
        .i_clk (i_clk),
        .i_en1 (w_en[0]),
        .i_en2 (w_en[1]),
        .i_v   (s_axis_tdata[CW-1:0]),
        .i_c   (w_cfg.centre_x),
        .i_mn  (w_cfg.min_x),
        .i_mx  (w_cfg.max_x),
        .i_cal (w_cfg.calibrated),
        .o_div (w_div_x[0])
    );

    jadm_axis_prep u_prep_y (
        .i_clk (i_clk),
        .i_en1 (w_en[0]),
        .i_en2 (w_en[1]),
        .i_v   (s_axis_tdata[2*CW-1:CW]),
        .i_c   (w_cfg.centre_y),
        .i_mn  (w_cfg.min_y),
        .i_mx  (w_cfg.max_y),
        .i_cal (w_cfg.calibrated),
        .o_div (w_div_y[0])
    );

    // Divider stages per axis
    generate
        for (g = 0; g < NDIV; g++) begin : g_div
            jadm_div_stage u_div_x (
                .i_clk (i_clk),
                .i_en  (w_en[g+2]),
                .i_div (w_div_x[g]),
                .o_div (w_div_x[g+1])
            );
            jadm_div_stage u_div_y (
                .i_clk (i_clk),
                .i_en  (w_en[g+2]),
                .i_div (w_div_y[g]),
                .o_div (w_div_y[g+1])
            );
        end
    endgenerate

    // Buttons ride alongside, inverted at entry
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (w_en[k]) begin
                if (k == 0) begin
                    r_btn[k] <= {~s_axis_tdata[ST_LSB + jadm_pkg::JADM_BTN2_BIT],
                                 ~s_axis_tdata[ST_LSB + jadm_pkg::JADM_BTN1_BIT]};
                end else begin
                    r_btn[k] <= r_btn[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // Final value: base plus or minus the scaled term
    assign w_qx = $signed({{(AW-QW){1'b0}}, w_div_x[NDIV].quo});
    assign w_qy = $signed({{(AW-QW){1'b0}}, w_div_y[NDIV].quo});

    always_comb begin
        w_axis_x = w_div_x[NDIV].base;
        if (w_div_x[NDIV].use_q) begin
            w_axis_x = w_div_x[NDIV].neg ? (w_div_x[NDIV].base - w_qx)
                                         : (w_div_x[NDIV].base + w_qx);
        end
        w_axis_y = w_div_y[NDIV].base;
        if (w_div_y[NDIV].use_q) begin
            w_axis_y = w_div_y[NDIV].neg ? (w_div_y[NDIV].base - w_qy)
                                         : (w_div_y[NDIV].base + w_qy);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_en[LAST]) begin
            r_axis_x <= w_axis_x;
            r_axis_y <= w_axis_y;
            r_dir    <= {w_div_y[NDIV].flag_hi, w_div_y[NDIV].flag_lo,
                         w_div_x[NDIV].flag_hi, w_div_x[NDIV].flag_lo};
        end
    end

    assign m_axis_tvalid = r_vld[LAST];
    assign m_axis_tdata  = {6'b000000, r_btn[LAST], r_dir, r_axis_y, r_axis_x};

    // Calibrated outputs stay within -128..128
    `JADM_CHK_IMPL(a_cal_range_x, i_clk, i_rst_n, m_axis_tvalid && w_cfg.calibrated,
        (r_axis_x >= jadm_pkg::JADM_AXIS_LO) && (r_axis_x <= jadm_pkg::JADM_AXIS_HI))
    `JADM_CHK_IMPL(a_cal_range_y, i_clk, i_rst_n, m_axis_tvalid && w_cfg.calibrated,
        (r_axis_y >= jadm_pkg::JADM_AXIS_LO) && (r_axis_y <= jadm_pkg::JADM_AXIS_HI))
    // X divider remainder stays below the segment length when the quotient takes part
    `JADM_CHK_IMPL(a_rem_below_dvs, i_clk, i_rst_n, r_vld[LAST-1] && w_div_x[NDIV].use_q,
        w_div_x[NDIV].rem < w_div_x[NDIV].dvs)
    // Input only refused while the first stage holds a sample
    `JADM_CHK_IMPL(a_ready_when_empty, i_clk, i_rst_n, !s_axis_tready, r_vld[0])
    // A stalled result is not dropped
    `JADM_CHK_NEXT(a_out_held, i_clk, i_rst_n, r_vld[LAST] && !m_axis_tready, r_vld[LAST])

endmodule

`default_nettype wire

>>> sv/jadm_cfg.sv
// Calibration register file behind the config write channel
`default_nettype none

module jadm_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [jadm_pkg::JADM_CNT_W-1:0] i_cfg_data,
    output jadm_pkg::t_cfg                     o_cfg
);

    jadm_pkg::t_cfg r_cfg;

    // Writes never stall
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register write, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (jadm_pkg::t_cfg_idx'(i_cfg_index))
                jadm_pkg::CFG_CENTRE_X:   r_cfg.centre_x   <= i_cfg_data;
                jadm_pkg::CFG_CENTRE_Y:   r_cfg.centre_y   <= i_cfg_data;
                jadm_pkg::CFG_MIN_X:      r_cfg.min_x      <= i_cfg_data;
                jadm_pkg::CFG_MIN_Y:      r_cfg.min_y      <= i_cfg_data;
                jadm_pkg::CFG_MAX_X:      r_cfg.max_x      <= i_cfg_data;
                jadm_pkg::CFG_MAX_Y:      r_cfg.max_y      <= i_cfg_data;
                jadm_pkg::CFG_CALIBRATED: r_cfg.calibrated <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/jadm_axis_prep.sv
// Front two stages of one axis: margins, direction flags, region and divider operands
`default_nettype none

module jadm_axis_prep (
    input  wire logic                            i_clk,
    input  wire logic                            i_en1,
    input  wire logic                            i_en2,
    input  wire logic [jadm_pkg::JADM_CNT_W-1:0] i_v,
    input  wire logic [jadm_pkg::JADM_CNT_W-1:0] i_c,
    input  wire logic [jadm_pkg::JADM_CNT_W-1:0] i_mn,
    input  wire logic [jadm_pkg::JADM_CNT_W-1:0] i_mx,
    input  wire logic                            i_cal,
    output jadm_pkg::t_div                       o_div
);

    localparam int CW = jadm_pkg::JADM_CNT_W;
    localparam int WW = jadm_pkg::JADM_WIDE_W;

    logic signed [WW-1:0] w_c_s, w_mn_s, w_mx_s;
    logic signed [WW-1:0] w_dlo, w_tlo, w_lo, w_dhi, w_thi, w_hi;
    logic [CW:0]          w_c3h;
    logic [WW-1:0]        w_c3;
    logic                 w_fl, w_fh;

    logic [CW-1:0]        r_v;
    logic signed [WW-1:0] r_lo, r_hi;
    logic                 r_fl, r_fh;

    logic signed [WW-1:0] w_vs, w_raw, w_nlo, w_dvlo, w_nhi, w_dvhi;
    jadm_pkg::t_div       n_div, r_div;

    assign w_c_s  = $signed({2'b00, i_c});
    assign w_mn_s = $signed({2'b00, i_mn});
    assign w_mx_s = $signed({2'b00, i_mx});

    // Stage one: dead-zone edges, eighth of each half-range truncated toward zero
    always_comb begin
        w_dlo = w_c_s - w_mn_s;
        w_tlo = w_dlo[WW-1] ? ((w_dlo + 19'sd7) >>> 3) : (w_dlo >>> 3);
        w_lo  = w_c_s - w_tlo;
        w_dhi = w_mx_s - w_c_s;
        w_thi = w_dhi[WW-1] ? ((w_dhi + 19'sd7) >>> 3) : (w_dhi >>> 3);
        w_hi  = w_c_s + w_thi;
    end

    // Stage one: direction thresholds at half and three halves of the centre
    assign w_c3  = {2'b00, i_c} + {1'b0, i_c, 1'b0};
    assign w_c3h = w_c3[WW-1:1];
    assign w_fl  = (i_v < {1'b0, i_c[CW-1:1]});
    assign w_fh  = ({1'b0, i_v} > w_c3h);

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_v  <= i_v;
            r_lo <= w_lo;
            r_hi <= w_hi;
            r_fl <= w_fl;
            r_fh <= w_fh;
        end
    end

    // Stage two operands
    assign w_vs   = $signed({2'b00, r_v});
    assign w_raw  = w_vs - w_c_s;
    assign w_nlo  = w_vs - w_mn_s;
    assign w_dvlo = r_lo - w_mn_s;
    assign w_nhi  = w_mx_s - w_vs;
    assign w_dvhi = w_mx_s - r_hi;

    // Stage two: pick the segment of the piecewise map
    always_comb begin
        n_div         = '0;
        n_div.flag_lo = r_fl;
        n_div.flag_hi = r_fh;
        if (!i_cal) begin
            n_div.base = w_raw[jadm_pkg::JADM_AXIS_W-1:0];
        end else begin
            priority if (w_vs < w_mn_s) begin
                n_div.base = jadm_pkg::JADM_AXIS_LO;
            end else if (w_vs < r_lo) begin
                n_div.base  = jadm_pkg::JADM_AXIS_LO;
                n_div.use_q = 1'b1;
                n_div.rem   = w_nlo[CW-1:0];
                n_div.dvs   = w_dvlo[CW-1:0];
            end else if (w_vs <= r_hi) begin
                n_div.base = jadm_pkg::JADM_AXIS_ZERO;
            end else if (w_vs <= w_mx_s) begin
                n_div.base  = jadm_pkg::JADM_AXIS_HI;
                n_div.use_q = 1'b1;
                n_div.neg   = 1'b1;
                n_div.rem   = w_nhi[CW-1:0];
                n_div.dvs   = w_dvhi[CW-1:0];
            end else begin
                n_div.base = jadm_pkg::JADM_AXIS_HI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

`default_nettype wire

>>> sv/jadm_div_stage.sv
// One restoring division step: one quotient bit of remainder*128/segment
`default_nettype none

module jadm_div_stage (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire jadm_pkg::t_div i_div,
    output jadm_pkg::t_div      o_div
);

    localparam int CW = jadm_pkg::JADM_CNT_W;

    logic [CW:0]    w_r2;
    logic [CW:0]    w_diff;
    logic           w_ge;
    jadm_pkg::t_div n_div, r_div;

    // Shift remainder, trial subtract
    assign w_r2   = {i_div.rem, 1'b0};
    assign w_ge   = (w_r2 >= {1'b0, i_div.dvs});
    assign w_diff = w_r2 - {1'b0, i_div.dvs};

    always_comb begin
        n_div     = i_div;
        n_div.rem = w_ge ? w_diff[CW-1:0] : w_r2[CW-1:0];
        n_div.quo = {i_div.quo[jadm_pkg::JADM_Q_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

`default_nettype wire
